// ===== rtl/vmm_pkg.sv =====
package vmm_pkg;

    // configuration register width and register indexes
    localparam int CFG_W = 7;
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    // request commands
    localparam logic CMD_VECTOR = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // classification of one queued request
    typedef struct packed {
        logic cmd;
        logic first_row;
        logic last_row;
        logic last_col;
    } entry_flags_t;

endpackage

// ===== rtl/vmm_front.sv =====
module vmm_front #(
    parameter int MAX_DIM    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [vmm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [DATA_WIDTH-1:0]       value,
    input  logic                        q_full,
    output logic                        push,
    output vmm_pkg::entry_flags_t       ent_flags,
    output logic [DATA_WIDTH-1:0]       ent_value,
    output logic [$clog2(MAX_DIM)-1:0]  ent_row,
    output logic [$clog2(MAX_DIM)-1:0]  ent_col
);
    import vmm_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CW    = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

    logic [CFG_W-1:0] row_count_reg, row_count_next;
    logic [CFG_W-1:0] column_count_reg, column_count_next;
    logic [IDX_W-1:0] load_idx_reg, load_idx_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] rows_m1;
    logic [IDX_W-1:0] cols_m1;

    // clamp count to 1..MAX_DIM, return last position
    function automatic logic [IDX_W-1:0] last_pos(input logic [CFG_W-1:0] cnt);
        logic [CW-1:0] ext;
        ext = CW'(cnt);
        if (ext == '0)
            ext = CW'(1);
        else if (ext > CW'(MAX_DIM))
            ext = CW'(MAX_DIM);
        return IDX_W'(ext - CW'(1));
    endfunction

    assign rows_m1  = last_pos(row_count_reg);
    assign cols_m1  = last_pos(column_count_reg);
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign ent_value           = value;
    assign ent_row             = (cmd == CMD_VECTOR) ? load_idx_reg : row_reg;
    assign ent_col             = col_reg;
    assign ent_flags.cmd       = cmd;
    assign ent_flags.first_row = (row_reg == '0);
    assign ent_flags.last_row  = (row_reg == rows_m1);
    assign ent_flags.last_col  = (col_reg == cols_m1);

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        load_idx_next     = load_idx_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_next = cfg_data;
                CFG_COLUMN_COUNT: column_count_next = cfg_data;
                default:          ;
            endcase
            load_idx_next = '0;
            row_next      = '0;
            col_next      = '0;
        end
        else if (push)
        begin
            if (cmd == CMD_VECTOR)
            begin
                load_idx_next = (load_idx_reg == rows_m1) ? '0 : load_idx_reg + 1'b1;
            end
            else if (col_reg == cols_m1)
            begin
                col_next = '0;
                row_next = (row_reg == rows_m1) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(1);
            column_count_reg <= CFG_W'(1);
            load_idx_reg     <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            load_idx_reg     <= load_idx_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
        end
    end

endmodule

// ===== rtl/vmm_queue.sv =====
module vmm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    import vmm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/vmm_back.sv =====
module vmm_back #(
    parameter int MAX_DIM    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        pop,
    input  vmm_pkg::entry_flags_t       ent_flags,
    input  logic [DATA_WIDTH-1:0]       ent_value,
    input  logic [$clog2(MAX_DIM)-1:0]  ent_row,
    input  logic [$clog2(MAX_DIM)-1:0]  ent_col,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [DATA_WIDTH-1:0]       product_value,
    output logic [$clog2(MAX_DIM)-1:0]  column_index,
    output logic                        last_flag
);
    import vmm_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int H     = (DATA_WIDTH + 1) / 2;   // low half width
    localparam int L     = DATA_WIDTH - H;         // high half width

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    logic [DATA_WIDTH-1:0] vector_store [MAX_DIM];
    logic [DATA_WIDTH-1:0] column_acc   [MAX_DIM];

    logic [2:0]            state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] product_value_reg;
    logic [IDX_W-1:0]      column_index_reg;
    logic                  last_flag_reg;

    logic [DATA_WIDTH-1:0] work_value_reg;
    logic [IDX_W-1:0]      work_row_reg;
    logic [IDX_W-1:0]      work_col_reg;
    entry_flags_t          work_flags_reg;
    logic [DATA_WIDTH-1:0] vec_rd_reg;
    logic [DATA_WIDTH-1:0] acc_rd_reg;
    logic [DATA_WIDTH-1:0] pp_ll_reg;
    logic [L-1:0]          pp_lh_reg;
    logic [L-1:0]          pp_hl_reg;
    logic [DATA_WIDTH-1:0] prod_reg;

    logic [2*H-1:0]        ll_full;
    logic [L-1:0]          lh_prod;
    logic [L-1:0]          hl_prod;
    logic [DATA_WIDTH-1:0] prod_next;
    logic [DATA_WIDTH-1:0] acc_sum;
    logic                  vec_we;
    logic                  acc_we;
    logic                  load_work;
    logic                  out_load;

    // split multiply: only the low DATA_WIDTH bits of the product are kept
    assign ll_full   = (2*H)'(vec_rd_reg[H-1:0]) * (2*H)'(work_value_reg[H-1:0]);
    assign lh_prod   = L'(vec_rd_reg[H-1:0]) * work_value_reg[DATA_WIDTH-1:H];
    assign hl_prod   = vec_rd_reg[DATA_WIDTH-1:H] * L'(work_value_reg[H-1:0]);
    assign prod_next = pp_ll_reg + {L'(pp_lh_reg + pp_hl_reg), H'(0)};
    // first row overwrites, so a never-written accumulator is not used
    assign acc_sum   = (work_flags_reg.first_row ? '0 : acc_rd_reg) + prod_reg;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        vec_we     = 1'b0;
        acc_we     = 1'b0;
        load_work  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (ent_flags.cmd == CMD_VECTOR)
                    begin
                        vec_we = 1'b1;
                    end
                    else
                    begin
                        load_work  = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (!work_flags_reg.last_row)
                begin
                    acc_we     = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    acc_we     = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_work)
        begin
            work_value_reg <= ent_value;
            work_row_reg   <= ent_row;
            work_col_reg   <= ent_col;
            work_flags_reg <= ent_flags;
        end
        if (state_reg == ST_MUL)
        begin
            pp_ll_reg <= ll_full[DATA_WIDTH-1:0];
            pp_lh_reg <= lh_prod;
            pp_hl_reg <= hl_prod;
        end
        if (state_reg == ST_SUM)
            prod_reg <= prod_next;
        if (out_load)
        begin
            product_value_reg <= acc_sum;
            column_index_reg  <= work_col_reg;
            last_flag_reg     <= work_flags_reg.last_col;
        end
    end

    // vector store and column accumulators, registered reads
    always_ff @(posedge clk)
    begin
        if (vec_we)
            vector_store[ent_row] <= ent_value;
        if (acc_we)
            column_acc[work_col_reg] <= acc_sum;
        vec_rd_reg <= vector_store[work_row_reg];
        acc_rd_reg <= column_acc[work_col_reg];
    end

    assign out_valid     = out_valid_reg;
    assign product_value = product_value_reg;
    assign column_index  = column_index_reg;
    assign last_flag     = last_flag_reg;

endmodule

// ===== rtl/vector_matrix_multiply_core.sv =====
// Row vector times matrix, integer, wrapping modulo 2^DATA_WIDTH.
// Request channel: in_valid/in_stall with cmd and value. cmd 0 loads the
//   next vector element, cmd 1 supplies the next matrix element, row-major.
// Result channel: out_valid/out_stall with product_value, column_index and
//   last_flag. One result per matrix element of the last row; last_flag
//   marks the final column.
// Config port: cfg_write/cfg_index/cfg_data, index 0 row_count, index 1
//   column_count. A write restarts the load and matrix positions.
// Back end: a vector load is stored in its idle step; a matrix element
//   passes pop, memory read, multiply, product sum and accumulate steps,
//   set by the single shared multiply-accumulate path in vmm_back. No new
//   element is popped before the last one is through; a last-row result
//   is loaded into the result register from the accumulate step.
// A 4-entry queue parts the front end from the back end, so requests are
//   taken while the back end works; in_stall rises only when it is full.
// Reset: counts go to 1, positions to 0, queue and result register empty.
//   Memories are not cleared; no clearing pass is run.
// Receiver stall: the result register holds; the back end waits in its
//   accumulate step and the queue then fills up to stall the sender.
module vector_matrix_multiply_core #(
    parameter int MAX_DIM    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [vmm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [DATA_WIDTH-1:0]       value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [DATA_WIDTH-1:0]       product_value,
    output logic [$clog2(MAX_DIM)-1:0]  column_index,
    output logic                        last_flag
);
    import vmm_pkg::*;

    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int FLAGS_W = $bits(entry_flags_t);
    localparam int Q_W     = FLAGS_W + DATA_WIDTH + 2 * IDX_W;

    // front side of the queue
    logic                  push;
    logic                  q_full;
    entry_flags_t          f_flags;
    logic [DATA_WIDTH-1:0] f_value;
    logic [IDX_W-1:0]      f_row;
    logic [IDX_W-1:0]      f_col;

    // back side of the queue
    logic                  pop;
    logic                  q_empty;
    logic [Q_W-1:0]        q_rdata;
    entry_flags_t          b_flags;
    logic [DATA_WIDTH-1:0] b_value;
    logic [IDX_W-1:0]      b_row;
    logic [IDX_W-1:0]      b_col;

    assign {b_flags, b_value, b_row, b_col} = q_rdata;

    vmm_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .q_full    (q_full),
        .push      (push),
        .ent_flags (f_flags),
        .ent_value (f_value),
        .ent_row   (f_row),
        .ent_col   (f_col)
    );

    vmm_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_flags, f_value, f_row, f_col}),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    vmm_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .pop           (pop),
        .ent_flags     (b_flags),
        .ent_value     (b_value),
        .ent_row       (b_row),
        .ent_col       (b_col),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .product_value (product_value),
        .column_index  (column_index),
        .last_flag     (last_flag)
    );

endmodule

// ===== rtl/vmm_checker.sv =====
module vmm_checker #(
    parameter int MAX_DIM    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [DATA_WIDTH-1:0]      product_value,
    input  logic [$clog2(MAX_DIM)-1:0] column_index,
    input  logic                       last_flag
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product_value)
            && $stable(column_index) && $stable(last_flag))
        else $error("stalled result changed");

    // queue fills only through a request taken the cycle before
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("in_stall rose without a request");

    // no result right out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("channels busy after reset");

    // the multiply-accumulate steps of the back end space results apart
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid || $past(out_valid, 2))
        else $error("results closer than the accumulate path allows");

endmodule

bind vector_matrix_multiply_core vmm_checker #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
) u_vmm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .product_value (product_value),
    .column_index  (column_index),
    .last_flag     (last_flag)
);
